>>> hdl/gcdfs_pkg.sv
// Shared constants, payload types and state codes for the graph connectivity block.
`default_nettype none
package gcdfs_pkg;

	localparam int MAX_NODES = 64;
	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int CNT_W = NODE_W + 1;

	typedef enum logic [1:0] {
		FUNC_CONNECT = 2'd0,
		FUNC_SAME    = 2'd1,
		FUNC_ALL     = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} in_item_t;

	typedef struct packed {
		logic answer;
		logic status;
	} out_item_t;

	typedef struct packed {
		logic                 rd_en;
		logic [NODE_W-1:0]    rd_addr;
		logic                 wr_en;
		logic [NODE_W-1:0]    wr_addr;
		logic [MAX_NODES-1:0] wr_data;
	} adj_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CON_A,
		ST_CON_B,
		ST_SCAN,
		ST_PUSH,
		ST_POP,
		ST_LOAD_ROW,
		ST_FINISH
	} state_t;

endpackage
`default_nettype wire

>>> hdl/gcdfs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module gcdfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> hdl/gcdfs_adj_store.sv
// Adjacency matrix store: row memory plus per-row valid flags that make unwritten rows read as zero.
`default_nettype none
module gcdfs_adj_store (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gcdfs_pkg::adj_req_t           req,
	output logic [gcdfs_pkg::MAX_NODES-1:0]    rd_row
);
	import gcdfs_pkg::*;

	logic [MAX_NODES-1:0] row_valid_q;
	logic                 rd_valid_s1;
	logic [MAX_NODES-1:0] ram_row;

	gcdfs_ram #(
		.WIDTH(MAX_NODES),
		.DEPTH(MAX_NODES)
	) u_rows (
		.clk    (clk),
		.wr_en  (req.wr_en),
		.wr_addr(req.wr_addr),
		.wr_data(req.wr_data),
		.rd_en  (req.rd_en),
		.rd_addr(req.rd_addr),
		.rd_data(ram_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				row_valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_s1 <= row_valid_q[req.rd_addr];
			end
		end
	end

	assign rd_row = rd_valid_s1 ? ram_row : '0;

endmodule
`default_nettype wire

>>> hdl/graph_connectivity_dfs.sv
// Top level: operation sequencer, depth-first walk control, walk stack and node count register.
// From input transfer to output register: connect reads and rewrites row a, then row b; an
// error, a trivial query or an unused code goes straight to the output load; a walk reads the
// start row, then pops the stack and reads one row per pushed node, pushing fresh neighbours.
// One operation is in flight at a time; the next transfer can follow in the cycle after the load.
// Reset empties the graph at once through per-row valid flags and sets node_count to 64.
`default_nettype none
module graph_connectivity_dfs (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire gcdfs_pkg::in_item_t     in_data,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output gcdfs_pkg::out_item_t         out_data,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [gcdfs_pkg::CNT_W-1:0] cfg_data
);
	import gcdfs_pkg::*;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     node_count_q;
	logic [CNT_W-1:0]     n_eff;
	logic [MAX_NODES-1:0] active_mask;

	logic [1:0]           func_q, func_d;
	logic [NODE_W-1:0]    a_q, a_d, b_q, b_d;
	logic                 ans_q, ans_d, status_q, status_d;
	logic [MAX_NODES-1:0] visited_q, visited_d;
	logic [MAX_NODES-1:0] fresh_q, fresh_d;
	logic [CNT_W-1:0]     depth_q, depth_d, depth_m1;

	adj_req_t             adj_req;
	logic [MAX_NODES-1:0] adj_row;

	logic                 stk_wr_en, stk_rd_en;
	logic [NODE_W-1:0]    stk_wr_addr, stk_rd_addr, stk_wr_data, stk_rd_data;

	logic [MAX_NODES-1:0] scan_fresh, push_src, push_low, push_rest;
	logic [NODE_W-1:0]    push_idx;
	logic                 err, out_load, out_valid_q;
	out_item_t            out_q;

	gcdfs_adj_store u_adj (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (adj_req),
		.rd_row(adj_row)
	);

	gcdfs_ram #(
		.WIDTH(NODE_W),
		.DEPTH(MAX_NODES)
	) u_stack (
		.clk    (clk),
		.wr_en  (stk_wr_en),
		.wr_addr(stk_wr_addr),
		.wr_data(stk_wr_data),
		.rd_en  (stk_rd_en),
		.rd_addr(stk_rd_addr),
		.rd_data(stk_rd_data)
	);

	assign n_eff = (node_count_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_q;
	assign active_mask = (n_eff == CNT_W'(MAX_NODES)) ? '1 :
		((MAX_NODES'(1) << n_eff[NODE_W-1:0]) - MAX_NODES'(1));
	assign err = ({1'b0, in_data.node_a} >= n_eff) || ({1'b0, in_data.node_b} >= n_eff);
	assign depth_m1 = depth_q - CNT_W'(1);

	assign scan_fresh = adj_row & ~visited_q & active_mask;
	assign push_src = (state_q == ST_SCAN) ? scan_fresh : fresh_q;
	assign push_low = push_src & (~push_src + MAX_NODES'(1));
	assign push_rest = push_src & ~push_low;

	always_comb begin
		push_idx = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			if (push_low[i]) begin
				push_idx = NODE_W'(i);
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		adj_req = '0;
		stk_wr_en = 1'b0;
		stk_wr_addr = depth_q[NODE_W-1:0];
		stk_wr_data = push_idx;
		stk_rd_en = 1'b0;
		stk_rd_addr = depth_m1[NODE_W-1:0];
		func_d = func_q;
		a_d = a_q;
		b_d = b_q;
		ans_d = ans_q;
		status_d = status_q;
		visited_d = visited_q;
		fresh_d = fresh_q;
		depth_d = depth_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					func_d = in_data.func;
					a_d = in_data.node_a;
					b_d = in_data.node_b;
					ans_d = 1'b0;
					status_d = 1'b0;
					depth_d = '0;
					if ((in_data.func == FUNC_CONNECT || in_data.func == FUNC_SAME) && err) begin
						status_d = 1'b1;
						state_d = ST_FINISH;
					end else if (in_data.func == FUNC_CONNECT) begin
						adj_req.rd_en = 1'b1;
						adj_req.rd_addr = in_data.node_a;
						state_d = ST_CON_A;
					end else if (in_data.func == FUNC_SAME) begin
						visited_d = MAX_NODES'(1) << in_data.node_a;
						adj_req.rd_en = 1'b1;
						adj_req.rd_addr = in_data.node_a;
						state_d = ST_SCAN;
					end else if (in_data.func == FUNC_ALL) begin
						if (n_eff <= CNT_W'(1)) begin
							ans_d = 1'b1;
							state_d = ST_FINISH;
						end else begin
							visited_d = MAX_NODES'(1);
							adj_req.rd_en = 1'b1;
							adj_req.rd_addr = '0;
							state_d = ST_SCAN;
						end
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_CON_A: begin
				adj_req.wr_en = 1'b1;
				adj_req.wr_addr = a_q;
				adj_req.wr_data = adj_row | (MAX_NODES'(1) << b_q);
				adj_req.rd_en = 1'b1;
				adj_req.rd_addr = b_q;
				state_d = ST_CON_B;
			end
			ST_CON_B: begin
				adj_req.wr_en = 1'b1;
				adj_req.wr_addr = b_q;
				adj_req.wr_data = adj_row | (MAX_NODES'(1) << a_q);
				state_d = ST_FINISH;
			end
			ST_SCAN: begin
				visited_d = visited_q | scan_fresh;
				if (push_src != '0) begin
					stk_wr_en = 1'b1;
					depth_d = depth_q + CNT_W'(1);
				end
				fresh_d = push_rest;
				state_d = (push_rest != '0) ? ST_PUSH : ST_POP;
			end
			ST_PUSH: begin
				stk_wr_en = 1'b1;
				depth_d = depth_q + CNT_W'(1);
				fresh_d = push_rest;
				if (push_rest == '0) begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				if (depth_q == '0) begin
					if (func_q == FUNC_SAME) begin
						ans_d = visited_q[b_q];
					end else begin
						ans_d = ((visited_q & active_mask) == active_mask);
					end
					state_d = ST_FINISH;
				end else begin
					stk_rd_en = 1'b1;
					depth_d = depth_m1;
					state_d = ST_LOAD_ROW;
				end
			end
			ST_LOAD_ROW: begin
				adj_req.rd_en = 1'b1;
				adj_req.rd_addr = stk_rd_data;
				state_d = ST_SCAN;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(MAX_NODES);
			out_valid_q <= 1'b0;
			depth_q <= '0;
			visited_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			depth_q <= depth_d;
			visited_q <= visited_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q <= func_d;
		a_q <= a_d;
		b_q <= b_d;
		ans_q <= ans_d;
		status_q <= status_d;
		fresh_q <= fresh_d;
		if (out_load) begin
			out_q.answer <= ans_q;
			out_q.status <= status_q;
		end
	end

endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the graph connectivity block with a scoreboard that tracks the graph.
module testbench;
	import gcdfs_pkg::*;

	localparam int LIMIT = 1_200_000;
	localparam int PRINT_CAP = 50;

	typedef struct {
		in_item_t  op;
		out_item_t reply;
	} pending_t;

	class graph_tracker;
		logic [MAX_NODES-1:0] adj [MAX_NODES];
		logic [CNT_W-1:0]     node_count;
		pending_t             pending_replies [$];
		int                   mismatches;

		function new();
			foreach (adj[i]) adj[i] = '0;
			node_count = CNT_W'(MAX_NODES);
			mismatches = 0;
		endfunction

		function int nodes_live();
			return (node_count > MAX_NODES) ? MAX_NODES : int'(node_count);
		endfunction

		function logic [MAX_NODES-1:0] reachable_from(int start, int n);
			logic [MAX_NODES-1:0] seen;
			int                   stack [$];
			int                   u;
			seen = '0;
			seen[start] = 1'b1;
			stack.push_back(start);
			while (stack.size() != 0) begin
				u = stack.pop_back();
				for (int w = 0; w < n; w++) begin
					if (adj[u][w] && !seen[w]) begin
						seen[w] = 1'b1;
						stack.push_back(w);
					end
				end
			end
			return seen;
		endfunction

		function out_item_t compute_reply(in_item_t op);
			out_item_t            r;
			logic [MAX_NODES-1:0] seen;
			int                   n;
			int                   a;
			int                   b;
			r = '0;
			n = nodes_live();
			a = op.node_a;
			b = op.node_b;
			case (func_t'(op.func))
				FUNC_CONNECT, FUNC_SAME: begin
					if (a >= n || b >= n) begin
						r.status = 1'b1;
					end else if (func_t'(op.func) == FUNC_CONNECT) begin
						adj[a][b] = 1'b1;
						adj[b][a] = 1'b1;
					end else begin
						seen = reachable_from(a, n);
						r.answer = seen[b];
					end
				end
				FUNC_ALL: begin
					r.answer = 1'b1;
					if (n > 1) begin
						seen = reachable_from(0, n);
						for (int w = 0; w < n; w++) begin
							if (!seen[w]) r.answer = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
			return r;
		endfunction

		function void note_op(in_item_t op);
			pending_t p;
			p.op = op;
			p.reply = compute_reply(op);
			pending_replies.push_back(p);
		endfunction

		function int outstanding();
			return pending_replies.size();
		endfunction

		task report_mismatch(string what);
			if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		task check_reply(out_item_t got);
			pending_t p;
			if (pending_replies.size() == 0) begin
				report_mismatch($sformatf("reply answer=%0b status=%0b with none expected",
					got.answer, got.status));
			end else begin
				p = pending_replies.pop_front();
				if (got.answer !== p.reply.answer)
					report_mismatch($sformatf("func=%0d a=%0d b=%0d answer %0b, expected %0b",
						p.op.func, p.op.node_a, p.op.node_b, got.answer, p.reply.answer));
				if (got.status !== p.reply.status)
					report_mismatch($sformatf("func=%0d a=%0d b=%0d status %0b, expected %0b",
						p.op.func, p.op.node_a, p.op.node_b, got.status, p.reply.status));
			end
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_ready;
	out_item_t        out_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data;

	bit           idle_on;
	bit           hold_req;
	int           cycles;
	graph_tracker tracker;

	graph_connectivity_dfs uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL graph_connectivity_dfs");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			if (hold_req) begin
				out_ready = 1'b0;
				hold_req = 1'b0;
				repeat (400) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
				repeat ($urandom_range(1, 24)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) tracker.check_reply(out_data);
	end

	task automatic send_op(in_item_t op);
		in_data = op;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_op(op);
		@(negedge clk);
	endtask

	task automatic send_fields(func_t f, int a, int b);
		in_item_t op;
		op.func = f;
		op.node_a = NODE_W'(a);
		op.node_b = NODE_W'(b);
		send_op(op);
	endtask

	task automatic maybe_gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	task automatic wait_quiet();
		in_valid = 1'b0;
		while (tracker.outstanding() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_count(int v);
		wait_quiet();
		cfg_data = CNT_W'(v);
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.node_count = CNT_W'(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int pick_node(int live);
		if (live > 0 && $urandom_range(0, 9) != 0) return $urandom_range(0, live - 1);
		return $urandom_range(0, MAX_NODES - 1);
	endfunction

	function automatic in_item_t random_op();
		in_item_t op;
		int       r;
		int       live;
		live = tracker.nodes_live();
		r = $urandom_range(0, 99);
		if (r < 40) op.func = FUNC_CONNECT;
		else if (r < 75) op.func = FUNC_SAME;
		else if (r < 94) op.func = FUNC_ALL;
		else op.func = FUNC_NONE;
		op.node_a = NODE_W'(pick_node(live));
		op.node_b = NODE_W'(pick_node(live));
		return op;
	endfunction

	initial begin
		int cnt;
		int top;
		tracker = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_fields(FUNC_ALL, 0, 0);
		send_fields(FUNC_SAME, 5, 5);
		send_fields(FUNC_SAME, 0, 63);
		send_fields(FUNC_CONNECT, 0, 63);
		send_fields(FUNC_CONNECT, 63, 63);
		send_fields(FUNC_SAME, 63, 0);
		send_fields(FUNC_SAME, 0, 63);
		send_fields(FUNC_NONE, 63, 63);
		write_count(1);
		send_fields(FUNC_ALL, 63, 63);
		send_fields(FUNC_SAME, 0, 0);
		send_fields(FUNC_CONNECT, 0, 1);
		send_fields(FUNC_SAME, 1, 0);
		write_count(0);
		send_fields(FUNC_ALL, 0, 0);
		send_fields(FUNC_CONNECT, 0, 0);
		send_fields(FUNC_SAME, 0, 0);
		write_count(2);
		send_fields(FUNC_ALL, 0, 0);
		send_fields(FUNC_CONNECT, 1, 0);
		send_fields(FUNC_ALL, 0, 0);
		send_fields(FUNC_SAME, 1, 0);
		send_fields(FUNC_CONNECT, 2, 0);
		send_fields(FUNC_SAME, 0, 63);
		write_count(127);
		send_fields(FUNC_ALL, 0, 0);
		send_fields(FUNC_SAME, 63, 1);
		send_fields(FUNC_NONE, 0, 0);

		for (int ph = 0; ph < 18; ph++) begin
			top = (4 + ph * 4 > MAX_NODES) ? MAX_NODES : 4 + ph * 4;
			case ($urandom_range(0, 15))
				0: cnt = 0;
				1: cnt = 1;
				2: cnt = 127;
				3: cnt = MAX_NODES;
				default: cnt = $urandom_range(2, top);
			endcase
			write_count(cnt);
			if (ph == 5) hold_req = 1'b1;
			for (int i = 0; i < 55; i++) begin
				if (ph == 9 && i == 27) wait_quiet();
				maybe_gap();
				send_op(random_op());
			end
		end

		idle_on = 1'b0;
		write_count(MAX_NODES);
		for (int i = 0; i < 150; i++) send_op(random_op());

		wait_quiet();
		repeat (40) @(negedge clk);
		if (tracker.mismatches == 0)
			$display("PASS graph_connectivity_dfs");
		else
			$display("FAIL graph_connectivity_dfs");
		$finish;
	end
endmodule
